@@ hdl/cesd_pkg.sv @@
// Shared types and constants of the C string escape decoder.
package cesd_pkg;

   localparam int unsigned CharWidth = 8;
   localparam int unsigned NibbleWidth = 4;
   localparam int unsigned BurstMax = 4;
   localparam int unsigned CountWidth = 3;

   localparam logic [CharWidth-1:0] CharNul = 8'h00;
   localparam logic [CharWidth-1:0] CharTab = 8'h09;
   localparam logic [CharWidth-1:0] CharNewline = 8'h0a;
   localparam logic [CharWidth-1:0] CharBackslash = 8'h5c;
   localparam logic [CharWidth-1:0] CharLowerN = 8'h6e;
   localparam logic [CharWidth-1:0] CharLowerT = 8'h74;
   localparam logic [CharWidth-1:0] CharLowerX = 8'h78;
   localparam logic [CharWidth-1:0] CharDigit0 = 8'h30;
   localparam logic [CharWidth-1:0] CharDigit9 = 8'h39;
   localparam logic [CharWidth-1:0] CharLowerA = 8'h61;
   localparam logic [CharWidth-1:0] CharLowerF = 8'h66;
   localparam logic [CharWidth-1:0] CaseBit = 8'h20;
   localparam logic [CharWidth-1:0] PrintLow = 8'h21;
   localparam logic [CharWidth-1:0] PrintHigh = 8'h7e;

   typedef enum logic [1:0] {
      PHASE_PLAIN = 2'd0,
      PHASE_ESC   = 2'd1,
      PHASE_HEX1  = 2'd2,
      PHASE_HEX2  = 2'd3
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic [NibbleWidth-1:0] high_nibble;
      logic                   halted;
   } parse_state_type;

   // Up to four output characters caused by one input word; bytes[0] goes first.
   typedef struct packed {
      logic [CountWidth-1:0]             count;
      logic [BurstMax-1:0][CharWidth-1:0] bytes;
      logic                              string_end;
      logic                              bad_escape;
   } burst_type;

   function automatic logic [CharWidth-1:0] hex_char(input logic [NibbleWidth-1:0] nib);
      logic [CharWidth-1:0] ch;
      if (nib < 4'd10) begin
         ch = CharDigit0 + {4'd0, nib};
      end else begin
         ch = CharLowerA + {4'd0, nib} - 8'd10;
      end
      return ch;
   endfunction

endpackage

@@ hdl/cesd_req_if.sv @@
// Input channel carrying one source character per word.
interface cesd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

@@ hdl/cesd_rsp_if.sv @@
// Result channel carrying one output character and its flags per word.
interface cesd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       string_end;
   logic       bad_escape;

   modport source (output valid, output out_byte, output run_last, output string_end,
                   output bad_escape, input ready);
   modport sink (input valid, input out_byte, input run_last, input string_end,
                 input bad_escape, output ready);
endinterface

@@ hdl/cesd_decode.sv @@
// Escape parser and text renderer for one input character.
module cesd_decode (
   input  logic [7:0]                cur_char,
   input  logic                      binary_mode,
   input  cesd_pkg::parse_state_type cur_state,
   output cesd_pkg::parse_state_type next_state,
   output cesd_pkg::burst_type       burst
);

   logic [7:0] folded;
   logic [3:0] hex_val;
   logic       hex_ok;
   logic       have_byte;
   logic       raise_error;
   logic [7:0] dec_byte;

   // A hex digit of either case; setting the case bit folds upper to lower.
   always_comb begin
      folded = cur_char | cesd_pkg::CaseBit;
      hex_ok = 1'b0;
      hex_val = 4'd0;
      if (cur_char >= cesd_pkg::CharDigit0 && cur_char <= cesd_pkg::CharDigit9) begin
         hex_ok = 1'b1;
         hex_val = 4'(cur_char - cesd_pkg::CharDigit0);
      end else if (folded >= cesd_pkg::CharLowerA && folded <= cesd_pkg::CharLowerF) begin
         hex_ok = 1'b1;
         hex_val = 4'(folded - cesd_pkg::CharLowerA + 8'd10);
      end
   end

   always_comb begin
      next_state = cur_state;
      burst = '0;
      have_byte = 1'b0;
      raise_error = 1'b0;
      dec_byte = cesd_pkg::CharNul;

      if (!cur_state.halted) begin
         unique case (cur_state.phase)
            cesd_pkg::PHASE_PLAIN: begin
               if (cur_char == cesd_pkg::CharNul) begin
                  if (!binary_mode) begin
                     burst.count = 3'd1;
                     burst.bytes[0] = cesd_pkg::CharNewline;
                     burst.string_end = 1'b1;
                  end
               end else if (cur_char == cesd_pkg::CharBackslash) begin
                  next_state.phase = cesd_pkg::PHASE_ESC;
               end else begin
                  have_byte = 1'b1;
                  dec_byte = cur_char;
               end
            end
            cesd_pkg::PHASE_ESC: begin
               next_state.phase = cesd_pkg::PHASE_PLAIN;
               unique case (cur_char)
                  cesd_pkg::CharLowerN: begin
                     have_byte = 1'b1;
                     dec_byte = cesd_pkg::CharNewline;
                  end
                  cesd_pkg::CharLowerT: begin
                     have_byte = 1'b1;
                     dec_byte = cesd_pkg::CharTab;
                  end
                  cesd_pkg::CharBackslash: begin
                     have_byte = 1'b1;
                     dec_byte = cesd_pkg::CharBackslash;
                  end
                  cesd_pkg::CharLowerX: begin
                     next_state.phase = cesd_pkg::PHASE_HEX1;
                  end
                  default: begin
                     raise_error = 1'b1;
                  end
               endcase
            end
            cesd_pkg::PHASE_HEX1: begin
               if (hex_ok) begin
                  next_state.high_nibble = hex_val;
                  next_state.phase = cesd_pkg::PHASE_HEX2;
               end else begin
                  raise_error = 1'b1;
               end
            end
            cesd_pkg::PHASE_HEX2: begin
               if (hex_ok) begin
                  next_state.phase = cesd_pkg::PHASE_PLAIN;
                  next_state.high_nibble = 4'd0;
                  have_byte = 1'b1;
                  dec_byte = {cur_state.high_nibble, hex_val};
               end else begin
                  raise_error = 1'b1;
               end
            end
            default: begin
               next_state.phase = cesd_pkg::PHASE_PLAIN;
            end
         endcase
      end

      if (raise_error) begin
         next_state.halted = 1'b1;
         next_state.phase = cesd_pkg::PHASE_PLAIN;
         next_state.high_nibble = 4'd0;
         burst.count = 3'd1;
         burst.bytes[0] = cesd_pkg::CharNul;
         burst.bad_escape = 1'b1;
      end else if (have_byte) begin
         if (binary_mode || (dec_byte >= cesd_pkg::PrintLow
                             && dec_byte <= cesd_pkg::PrintHigh)) begin
            burst.count = 3'd1;
            burst.bytes[0] = dec_byte;
         end else begin
            burst.count = 3'd4;
            burst.bytes[0] = cesd_pkg::CharBackslash;
            burst.bytes[1] = cesd_pkg::CharLowerX;
            burst.bytes[2] = cesd_pkg::hex_char(dec_byte[7:4]);
            burst.bytes[3] = cesd_pkg::hex_char(dec_byte[3:0]);
         end
      end
   end

endmodule

@@ hdl/c_escape_string_decoder.sv @@
// Top level: C string escape decoder with a four-word output shift register.
// The first output word is offered in the cycle after its input word is accepted.
// Throughput: one input word per cycle while the output is not stalled, also for words
// that give no output; a text escape byte gives four output words and holds the input.
// Reset (synchronous, active high) empties the output register, clears the parser and
// the error halt, and selects text mode.
module c_escape_string_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   cesd_req_if.sink          req_chan,
   cesd_rsp_if.source        rsp_chan
);

   logic                      binary_ff, binary_in;
   cesd_pkg::parse_state_type state_ff, state_in;
   cesd_pkg::parse_state_type state_next;
   cesd_pkg::burst_type       burst;
   logic [2:0]                count_ff, count_in;
   logic [3:0][7:0]           bytes_ff, bytes_in;
   logic                      end_ff, end_in;
   logic                      bad_ff, bad_in;
   logic                      accept;
   logic                      take;

   cesd_decode u_decode (
      .cur_char    (req_chan.char_code),
      .binary_mode (binary_ff),
      .cur_state   (state_ff),
      .next_state  (state_next),
      .burst       (burst)
   );

   assign take = rsp_chan.valid & rsp_chan.ready;
   // A new word may enter when the output register is empty or its last word leaves now.
   assign req_chan.ready = (count_ff == 3'd0) || (count_ff == 3'd1 && rsp_chan.ready);
   assign accept = req_chan.valid & req_chan.ready;

   assign rsp_chan.valid = (count_ff != 3'd0);
   assign rsp_chan.out_byte = bytes_ff[0];
   assign rsp_chan.run_last = (count_ff == 3'd1);
   assign rsp_chan.string_end = end_ff;
   assign rsp_chan.bad_escape = bad_ff;

   always_comb begin
      binary_in = csr_wr_en ? csr_wr_data : binary_ff;
      state_in = accept ? state_next : state_ff;
      if (accept) begin
         count_in = burst.count;
         bytes_in = burst.bytes;
         end_in = burst.string_end;
         bad_in = burst.bad_escape;
      end else if (take) begin
         count_in = count_ff - 3'd1;
         bytes_in = bytes_ff >> 8;
         end_in = end_ff;
         bad_in = bad_ff;
      end else begin
         count_in = count_ff;
         bytes_in = bytes_ff;
         end_in = end_ff;
         bad_in = bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         binary_ff <= 1'b0;
         state_ff <= '{phase: cesd_pkg::PHASE_PLAIN, high_nibble: 4'd0, halted: 1'b0};
         count_ff <= 3'd0;
      end else begin
         binary_ff <= binary_in;
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      end_ff <= end_in;
      bad_ff <= bad_in;
   end

endmodule
